/* rtl/core/scpf_pkg.sv */
// types and constants shared by the sphere collision penalty force block
// no dependencies; every other file of the block but scpf_fifo refers to this package by scoped names
package scpf_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned SQRT_STEPS  = 32;
   localparam int unsigned DIV_STEPS   = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPHERE_X          = 3'd0,
      CSR_SPHERE_Y          = 3'd1,
      CSR_SPHERE_Z          = 3'd2,
      CSR_SPHERE_RADIUS     = 3'd3,
      CSR_PARTICLE_RADIUS   = 3'd4,
      CSR_INVERSE_STIFFNESS = 3'd5
   } csr_index_type;

   localparam logic [30:0] SPHERE_RADIUS_RST     = 31'd65536;
   localparam logic [30:0] PARTICLE_RADIUS_RST   = 31'd3932;
   localparam logic [30:0] INVERSE_STIFFNESS_RST = 31'd65536;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } req_word_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] force_x;
      logic signed [31:0] force_y;
      logic signed [31:0] force_z;
   } rsp_word_type;

   typedef struct packed {
      logic signed [31:0] sphere_x;
      logic signed [31:0] sphere_y;
      logic signed [31:0] sphere_z;
      logic [30:0]        sphere_radius;
      logic [30:0]        particle_radius;
      logic [30:0]        inverse_stiffness;
   } cfg_type;

   // classified word handed from front to back
   typedef struct packed {
      logic            hit;
      logic [2:0][32:0] delta;
      logic [63:0]     dist_sq;
   } mid_word_type;

endpackage

/* rtl/core/scpf_fifo.sv */
// small first-word-fall-through queue held in flip-flops
// no dependencies beyond its parameters
module scpf_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/core/scpf_front.sv */
// front end: offsets from the sphere centre, squared distance and the hit test
// depends on scpf_pkg
module scpf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  scpf_pkg::cfg_type     cfg,
   input  logic                  in_push,
   input  scpf_pkg::req_word_type in_word,
   output logic                  in_full,
   output logic                  out_push,
   output scpf_pkg::mid_word_type out_word,
   input  logic                  out_full
);

   logic             en, accept;
   logic             s1_v_ff, s2_v_ff, s3_v_ff;
   logic [2:0][32:0] d1_in, d1_ff, a1_in, a1_ff, d2_ff;
   logic [2:0][65:0] sq2_in, sq2_ff;
   logic [31:0]      rsum;
   logic [63:0]      rr2_in, rr2_ff;
   logic [66:0]      sum3;
   scpf_pkg::mid_word_type s3_in, s3_ff;

   assign en       = !s3_v_ff || !out_full;
   assign in_full  = !en;
   assign accept   = in_push && en;
   assign out_push = s3_v_ff && !out_full;
   assign out_word = s3_ff;

   assign rsum = {1'b0, cfg.sphere_radius} + {1'b0, cfg.particle_radius};

   always_comb begin
      d1_in[0] = {in_word.pos_x[31], in_word.pos_x} - {cfg.sphere_x[31], cfg.sphere_x};
      d1_in[1] = {in_word.pos_y[31], in_word.pos_y} - {cfg.sphere_y[31], cfg.sphere_y};
      d1_in[2] = {in_word.pos_z[31], in_word.pos_z} - {cfg.sphere_z[31], cfg.sphere_z};
      for (int c = 0; c < 3; c++) begin
         a1_in[c]  = d1_in[c][32] ? (~d1_in[c] + 33'd1) : d1_in[c];
         sq2_in[c] = a1_ff[c] * a1_ff[c];
      end
      rr2_in = rsum * rsum;
      sum3   = {1'b0, sq2_ff[0]} + {1'b0, sq2_ff[1]} + {1'b0, sq2_ff[2]};
      s3_in.hit     = (sum3 <= {3'b000, rr2_ff});
      s3_in.delta   = d2_ff;
      // only a hit needs a root, so the back end sees zero otherwise
      s3_in.dist_sq = s3_in.hit ? sum3[63:0] : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= accept;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_ff  <= d1_in;
         a1_ff  <= a1_in;
         d2_ff  <= d1_ff;
         sq2_ff <= sq2_in;
         rr2_ff <= rr2_in;
         s3_ff  <= s3_in;
      end
   end

endmodule

/* rtl/core/scpf_back.sv */
// back end: pipelined square root, force scale, three pipelined dividers, saturation
// depends on scpf_pkg
module scpf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  scpf_pkg::cfg_type      cfg,
   input  logic                   in_empty,
   input  scpf_pkg::mid_word_type in_word,
   output logic                   in_pop,
   output logic                   out_push,
   output scpf_pkg::rsp_word_type out_word,
   input  logic                   out_full
);

   localparam int unsigned SQ = scpf_pkg::SQRT_STEPS;
   localparam int unsigned DV = scpf_pkg::DIV_STEPS;
   localparam int unsigned HIT_LEN = SQ + 4 + DV;

   typedef struct packed {
      logic [33:0]      rem;
      logic [31:0]      root;
      logic [63:0]      rad;
      logic [2:0]       neg;
      logic [2:0][32:0] mag;
   } sq_stage_type;

   typedef struct packed {
      logic [31:0]      len;
      logic [62:0]      scale;
      logic [2:0]       neg;
      logic [2:0][32:0] mag;
   } m1_type;

   typedef struct packed {
      logic [31:0]      len;
      logic [2:0]       neg;
      logic [2:0][64:0] p0;
      logic [2:0][63:0] p1;
   } m2_type;

   typedef struct packed {
      logic [31:0]      len;
      logic [2:0]       neg;
      logic [2:0][79:0] num;
   } m3_type;

   typedef struct packed {
      logic [31:0]      len;
      logic [2:0]       neg;
      logic [2:0]       ovf;
      logic [2:0][31:0] rem;
      logic [2:0][31:0] low;
      logic [2:0][31:0] quo;
   } dv_stage_type;

   logic          en;
   logic [SQ:0]   sqv_ff;
   logic          m1v_ff, m2v_ff, m3v_ff;
   logic [DV:0]   dvv_ff;
   logic          outv_ff;
   sq_stage_type  sq_in [SQ+1];
   sq_stage_type  sq_ff [SQ+1];
   m1_type        m1_in, m1_ff;
   m2_type        m2_in, m2_ff;
   m3_type        m3_in, m3_ff;
   dv_stage_type  dv_in [DV+1];
   dv_stage_type  dv_ff [DV+1];
   scpf_pkg::rsp_word_type out_in, out_ff;
   logic [31:0]   rsum, diff;
   logic [95:0]   prod [3];
   logic [31:0]   limit, magq, frc [3];
   logic          nz;
   logic [HIT_LEN:0] hit_line_ff;
   logic [DV:0]      hit_ff;

   assign en       = !outv_ff || !out_full;
   assign in_pop   = en && !in_empty;
   assign out_push = outv_ff && !out_full;
   assign out_word = out_ff;

   // entry: sign and magnitude of each offset, root search starts empty
   always_comb begin
      sq_in[0].rem  = '0;
      sq_in[0].root = '0;
      sq_in[0].rad  = in_word.dist_sq;
      for (int c = 0; c < 3; c++) begin
         sq_in[0].neg[c] = in_word.delta[c][32];
         sq_in[0].mag[c] = in_word.delta[c][32] ? (~in_word.delta[c] + 33'd1)
                                                : in_word.delta[c];
      end
   end

   // one root bit per stage
   for (genvar i = 0; i < SQ; i++) begin : g_sqrt
      logic [33:0] rem_sh, trial;
      logic        ge;
      always_comb begin
         rem_sh          = {sq_ff[i].rem[31:0], sq_ff[i].rad[63:62]};
         trial           = {sq_ff[i].root, 2'b01};
         ge              = (rem_sh >= trial);
         sq_in[i+1]      = sq_ff[i];
         sq_in[i+1].rem  = ge ? (rem_sh - trial) : rem_sh;
         sq_in[i+1].root = {sq_ff[i].root[30:0], ge};
         sq_in[i+1].rad  = {sq_ff[i].rad[61:0], 2'b00};
      end
   end

   for (genvar i = 0; i <= SQ; i++) begin : g_sqrt_reg
      always_ff @(posedge clock) begin
         if (en) begin
            sq_ff[i] <= sq_in[i];
         end
      end
   end

   // scale = (R - len) * k, then partial products, then the numerator over 2^16
   assign rsum = {1'b0, cfg.sphere_radius} + {1'b0, cfg.particle_radius};
   assign diff = rsum - sq_ff[SQ].root;

   always_comb begin
      m1_in.len   = sq_ff[SQ].root;
      m1_in.scale = diff * cfg.inverse_stiffness;
      m1_in.neg   = sq_ff[SQ].neg;
      m1_in.mag   = sq_ff[SQ].mag;

      m2_in.len = m1_ff.len;
      m2_in.neg = m1_ff.neg;
      m3_in.len = m2_ff.len;
      m3_in.neg = m2_ff.neg;
      for (int c = 0; c < 3; c++) begin
         m2_in.p0[c]  = m1_ff.mag[c] * m1_ff.scale[31:0];
         m2_in.p1[c]  = m1_ff.mag[c] * m1_ff.scale[62:32];
         prod[c]      = {31'd0, m2_ff.p0[c]} + {m2_ff.p1[c], 32'd0};
         m3_in.num[c] = prod[c][95:16];
      end

      dv_in[0].len = m3_ff.len;
      dv_in[0].neg = m3_ff.neg;
      for (int c = 0; c < 3; c++) begin
         // quotient of 2^32 or more saturates in any case
         dv_in[0].ovf[c] = (m3_ff.num[c][79:32] >= {16'd0, m3_ff.len});
         dv_in[0].rem[c] = m3_ff.num[c][63:32];
         dv_in[0].low[c] = m3_ff.num[c][31:0];
         dv_in[0].quo[c] = '0;
      end
   end

   // one quotient bit per stage for all three lanes
   for (genvar j = 0; j < DV; j++) begin : g_div
      logic [2:0][32:0] part, sub;
      logic [2:0]       ge;
      always_comb begin
         dv_in[j+1] = dv_ff[j];
         for (int c = 0; c < 3; c++) begin
            part[c] = {dv_ff[j].rem[c], dv_ff[j].low[c][31]};
            sub[c]  = part[c] - {1'b0, dv_ff[j].len};
            ge[c]   = (part[c] >= {1'b0, dv_ff[j].len});
            dv_in[j+1].rem[c] = ge[c] ? sub[c][31:0] : part[c][31:0];
            dv_in[j+1].low[c] = {dv_ff[j].low[c][30:0], 1'b0};
            dv_in[j+1].quo[c] = {dv_ff[j].quo[c][30:0], ge[c]};
         end
      end
   end

   for (genvar j = 0; j <= DV; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (en) begin
            dv_ff[j] <= dv_in[j];
         end
      end
   end

   // saturate, apply sign; a miss or a zero distance gives no force
   always_comb begin
      nz          = (dv_ff[DV].len != 32'd0);
      limit       = 32'h7fff_ffff;
      magq        = '0;
      out_in.hit  = 1'b0;
      for (int c = 0; c < 3; c++) begin
         limit  = dv_ff[DV].neg[c] ? 32'h8000_0000 : 32'h7fff_ffff;
         magq   = (dv_ff[DV].ovf[c] || (dv_ff[DV].quo[c] > limit)) ? limit
                                                                    : dv_ff[DV].quo[c];
         frc[c] = !nz ? 32'd0 : (dv_ff[DV].neg[c] ? (~magq + 32'd1) : magq);
      end
      // a miss carries a zero distance, so len is zero exactly when hit is clear
      // or the particle sits on the centre; hit travels as the valid-root flag below
      out_in.hit     = hit_ff[DV];
      out_in.force_x = frc[0];
      out_in.force_y = frc[1];
      out_in.force_z = frc[2];
   end

   // hit flag rides alongside the stages
   always_ff @(posedge clock) begin
      if (en) begin
         hit_line_ff <= {hit_line_ff[HIT_LEN-1:0], in_word.hit};
      end
   end

   for (genvar j = 0; j <= DV; j++) begin : g_hit_tap
      assign hit_ff[j] = hit_line_ff[SQ + 4 + j];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_ff  <= m1_in;
         m2_ff  <= m2_in;
         m3_ff  <= m3_in;
         out_ff <= out_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sqv_ff  <= '0;
         m1v_ff  <= 1'b0;
         m2v_ff  <= 1'b0;
         m3v_ff  <= 1'b0;
         dvv_ff  <= '0;
         outv_ff <= 1'b0;
      end else if (en) begin
         sqv_ff  <= {sqv_ff[SQ-1:0], in_pop};
         m1v_ff  <= sqv_ff[SQ];
         m2v_ff  <= m1v_ff;
         m3v_ff  <= m2v_ff;
         dvv_ff  <= {dvv_ff[DV-1:0], m3v_ff};
         outv_ff <= dvv_ff[DV];
      end
   end

endmodule

/* rtl/core/sphere_collision_penalty_force.sv */
// Sphere collision penalty force. Each req_ word is a particle position (Q16.16);
// each rsp_ word says whether the particle lies within particle_radius +
// sphere_radius of the sphere centre and, if so, the penalty force increment
// delta * (R - len) / len * inverse_stiffness, truncated and saturated to 32 bits,
// zero on a miss or at zero distance. One word is accepted per clock and one
// result leaves per clock unless a full queue stalls the pipeline. The back end
// holds the 32-stage square root and the 32-stage dividers. Registers are to be
// written through csr_ only while no word is in flight; the block does not enforce this.
// depends on scpf_pkg, scpf_fifo, scpf_front, scpf_back
module sphere_collision_penalty_force #(
   parameter int unsigned MID_DEPTH = 4,   // queue between front and back end
   parameter int unsigned OUT_DEPTH = 2    // result queue
) (
   input  logic                   clock,
   input  logic                   reset,
   // position words in
   input  logic                   req_push,
   input  scpf_pkg::req_word_type req_word,
   output logic                   req_full,
   // result words out
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output scpf_pkg::rsp_word_type rsp_word,
   // register writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [scpf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   localparam int unsigned MID_W = $bits(scpf_pkg::mid_word_type);
   localparam int unsigned RSP_W = $bits(scpf_pkg::rsp_word_type);

   scpf_pkg::cfg_type      cfg_ff;
   scpf_pkg::mid_word_type front_word, mid_word;
   scpf_pkg::rsp_word_type back_word;
   logic                   front_push, mid_full, mid_empty, mid_pop;
   logic                   back_push, out_full;
   logic [MID_W-1:0]       mid_rdata;
   logic [RSP_W-1:0]       out_rdata;

   // register file, always ready; unknown indexes are dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sphere_x          <= '0;
         cfg_ff.sphere_y          <= '0;
         cfg_ff.sphere_z          <= '0;
         cfg_ff.sphere_radius     <= scpf_pkg::SPHERE_RADIUS_RST;
         cfg_ff.particle_radius   <= scpf_pkg::PARTICLE_RADIUS_RST;
         cfg_ff.inverse_stiffness <= scpf_pkg::INVERSE_STIFFNESS_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            scpf_pkg::CSR_SPHERE_X:          cfg_ff.sphere_x          <= csr_data;
            scpf_pkg::CSR_SPHERE_Y:          cfg_ff.sphere_y          <= csr_data;
            scpf_pkg::CSR_SPHERE_Z:          cfg_ff.sphere_z          <= csr_data;
            scpf_pkg::CSR_SPHERE_RADIUS:     cfg_ff.sphere_radius     <= csr_data[30:0];
            scpf_pkg::CSR_PARTICLE_RADIUS:   cfg_ff.particle_radius   <= csr_data[30:0];
            scpf_pkg::CSR_INVERSE_STIFFNESS: cfg_ff.inverse_stiffness <= csr_data[30:0];
            default: begin
            end
         endcase
      end
   end

   // front end: offsets, squared distance, hit test
   scpf_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_push  (req_push),
      .in_word  (req_word),
      .in_full  (req_full),
      .out_push (front_push),
      .out_word (front_word),
      .out_full (mid_full)
   );

   // decouples the two halves so each stalls on its own
   scpf_fifo #(
      .WIDTH (MID_W),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock (clock),
      .reset (reset),
      .push  (front_push),
      .wdata (front_word),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rdata),
      .empty (mid_empty)
   );

   assign mid_word = scpf_pkg::mid_word_type'(mid_rdata);

   // back end: root, scale, divide, saturate
   scpf_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .in_empty (mid_empty),
      .in_word  (mid_word),
      .in_pop   (mid_pop),
      .out_push (back_push),
      .out_word (back_word),
      .out_full (out_full)
   );

   // result queue keeps the pipeline moving while the consumer waits
   scpf_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (OUT_DEPTH)
   ) u_out_fifo (
      .clock (clock),
      .reset (reset),
      .push  (back_push),
      .wdata (back_word),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (out_rdata),
      .empty (rsp_empty)
   );

   assign rsp_word = scpf_pkg::rsp_word_type'(out_rdata);

endmodule
